### design/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
package i2cee_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [6:0]  DEV_ADDR_RST    = 7'd80;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd200;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR    = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1,
        CFG_PHASE_TICKS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] mem_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_fail;
        logic [7:0] rd_data;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [7:0]  ack_timeout;
        logic [15:0] phase_ticks;
    } t_cfg;

endpackage

### design/i2cee_cfg.sv
// Configuration registers of the I2C EEPROM byte master.
module i2cee_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output i2cee_pkg::t_cfg                      o_cfg
);
    import i2cee_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= DEV_ADDR_RST;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RST;
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEV_ADDR:    r_cfg.dev_addr    <= i_cfg_data[6:0];
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data[7:0];
                CFG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/i2cee_seq.sv
// Bus phase sequencer: one step per accepted item, result from pre-step state.
module i2cee_seq #(
    parameter int TIMER_WIDTH = i2cee_pkg::TIMER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  i2cee_pkg::t_in_item   i_item,
    input  i2cee_pkg::t_cfg       i_cfg,
    output i2cee_pkg::t_out_item  o_res
);
    import i2cee_pkg::*;

    localparam int CW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;
    localparam logic [CW-1:0] TMASK = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

    typedef enum logic [4:0] {
        PH_IDLE, PH_STA_A, PH_STA_B, PH_STA_C, PH_STA_D,
        PH_BIT_A, PH_BIT_B, PH_BIT_C,
        PH_ACK_A, PH_ACK_W, PH_ACK_E,
        PH_RD_A, PH_RD_B, PH_RD_C, PH_RD_D,
        PH_STP_A, PH_STP_B, PH_STP_C
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic [3:0]             r_bit_cnt, n_bit_cnt;
    logic [2:0]             r_byte_idx, n_byte_idx;
    logic [7:0]             r_shift, n_shift;
    logic [7:0]             r_ack_wait, n_ack_wait;
    logic                   r_is_read, n_is_read;
    logic [7:0]             r_saddr, n_saddr;
    logic [7:0]             r_sdata, n_sdata;
    logic                   r_fail, n_fail;
    logic [7:0]             r_rbyte, n_rbyte;

    logic [CW-1:0]          lim_raw, lim, tick_sum;
    logic                   over;
    logic [TIMER_WIDTH-1:0] timer_adv;
    logic [2:0]             idx_inc;
    logic [3:0]             bit_inc;
    logic                   done;
    logic                   scl, sdo;

    // phase timer
    assign lim_raw   = CW'(i_cfg.phase_ticks) & TMASK;
    assign lim       = (lim_raw == '0) ? CW'(1) : lim_raw;
    assign tick_sum  = CW'(r_timer) + CW'(1);
    assign over      = (tick_sum >= lim);
    assign timer_adv = over ? '0 : (r_timer + TIMER_WIDTH'(1));

    assign idx_inc = r_byte_idx + 3'd1;
    assign bit_inc = r_bit_cnt + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit_cnt  = r_bit_cnt;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_ack_wait = r_ack_wait;
        n_is_read  = r_is_read;
        n_saddr    = r_saddr;
        n_sdata    = r_sdata;
        n_fail     = r_fail;
        n_rbyte    = r_rbyte;
        done       = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.func == FUNC_WRITE || i_item.func == FUNC_READ) begin
                    n_is_read  = (i_item.func == FUNC_READ);
                    n_saddr    = i_item.mem_addr;
                    n_sdata    = i_item.wr_data;
                    n_fail     = 1'b0;
                    n_byte_idx = '0;
                    n_bit_cnt  = '0;
                    n_ack_wait = '0;
                    n_timer    = '0;
                    n_phase    = PH_STA_A;
                end
            end
            PH_STA_A: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_STA_B;
            end
            PH_STA_B: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_STA_C;
            end
            PH_STA_C: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_STA_D;
            end
            PH_STA_D: begin
                n_timer = timer_adv;
                if (over) begin
                    n_shift   = {i_cfg.dev_addr, (r_byte_idx == 3'd2)};
                    n_bit_cnt = '0;
                    n_phase   = PH_BIT_A;
                end
            end
            PH_BIT_A: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_BIT_B;
            end
            PH_BIT_B: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_BIT_C;
            end
            PH_BIT_C: begin
                n_timer = timer_adv;
                if (over) begin
                    n_shift   = {r_shift[6:0], 1'b0};
                    n_bit_cnt = bit_inc;
                    n_phase   = (bit_inc >= 4'd8) ? PH_ACK_A : PH_BIT_A;
                end
            end
            PH_ACK_A: begin
                n_timer = timer_adv;
                if (over) begin
                    n_ack_wait = '0;
                    n_phase    = PH_ACK_W;
                end
            end
            PH_ACK_W: begin
                n_timer = '0;
                if (!i_item.sda_in) begin
                    n_ack_wait = '0;
                    n_phase    = PH_ACK_E;
                end else if (r_ack_wait >= i_cfg.ack_timeout) begin
                    n_fail     = 1'b1;
                    n_ack_wait = '0;
                    n_phase    = PH_ACK_E;
                end else begin
                    n_ack_wait = r_ack_wait + 8'd1;
                end
            end
            PH_ACK_E: begin
                n_timer = timer_adv;
                if (over) begin
                    n_byte_idx = idx_inc;
                    if (idx_inc == 3'd1) begin
                        n_shift   = r_saddr;
                        n_bit_cnt = '0;
                        n_phase   = PH_BIT_A;
                    end else if (idx_inc == 3'd2) begin
                        if (r_is_read) begin
                            n_phase = PH_STA_A;
                        end else begin
                            n_shift   = r_sdata;
                            n_bit_cnt = '0;
                            n_phase   = PH_BIT_A;
                        end
                    end else if (idx_inc == 3'd3 && r_is_read) begin
                        n_phase = PH_RD_A;
                    end else begin
                        n_phase = PH_STP_A;
                    end
                end
            end
            PH_RD_A: begin
                n_timer = timer_adv;
                if (over) begin
                    n_shift   = '0;
                    n_bit_cnt = '0;
                    n_phase   = PH_RD_B;
                end
            end
            PH_RD_B: begin
                n_timer = timer_adv;
                if (over) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_phase = PH_RD_C;
                end
            end
            PH_RD_C: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_RD_D;
            end
            PH_RD_D: begin
                n_timer = timer_adv;
                if (over) begin
                    n_bit_cnt = bit_inc;
                    if (bit_inc >= 4'd8) begin
                        n_rbyte = r_shift;
                        n_phase = PH_STP_A;
                    end else begin
                        n_phase = PH_RD_B;
                    end
                end
            end
            PH_STP_A: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_STP_B;
            end
            PH_STP_B: begin
                n_timer = timer_adv;
                if (over) n_phase = PH_STP_C;
            end
            PH_STP_C: begin
                n_timer = timer_adv;
                if (over) begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        endcase
    end

    // bus drive from current phase
    always_comb begin
        unique case (r_phase)
            PH_STA_A:                     begin scl = (r_byte_idx == 3'd0); sdo = 1'b1; end
            PH_STA_B:                     begin scl = 1'b1; sdo = 1'b1;       end
            PH_STA_C:                     begin scl = 1'b1; sdo = 1'b0;       end
            PH_STA_D:                     begin scl = 1'b0; sdo = 1'b0;       end
            PH_BIT_A, PH_BIT_C:           begin scl = 1'b0; sdo = r_shift[7]; end
            PH_BIT_B:                     begin scl = 1'b1; sdo = r_shift[7]; end
            PH_ACK_A, PH_ACK_E,
            PH_RD_A, PH_RD_D:             begin scl = 1'b0; sdo = 1'b1;       end
            PH_ACK_W, PH_RD_B, PH_RD_C:   begin scl = 1'b1; sdo = 1'b1;       end
            PH_STP_A:                     begin scl = 1'b0; sdo = 1'b0;       end
            PH_STP_B:                     begin scl = 1'b1; sdo = 1'b0;       end
            PH_STP_C:                     begin scl = 1'b1; sdo = 1'b1;       end
            default:                      begin scl = 1'b1; sdo = 1'b1;       end
        endcase
    end

    assign o_res.scl      = scl;
    assign o_res.sda_out  = sdo;
    assign o_res.busy_res = (r_phase != PH_IDLE);
    assign o_res.done_res = done;
    assign o_res.ack_fail = r_fail;
    assign o_res.rd_data  = r_rbyte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit_cnt  <= '0;
            r_byte_idx <= '0;
            r_shift    <= '0;
            r_ack_wait <= '0;
            r_is_read  <= 1'b0;
            r_saddr    <= '0;
            r_sdata    <= '0;
            r_fail     <= 1'b0;
            r_rbyte    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
            r_ack_wait <= n_ack_wait;
            r_is_read  <= n_is_read;
            r_saddr    <= n_saddr;
            r_sdata    <= n_sdata;
            r_fail     <= n_fail;
            r_rbyte    <= n_rbyte;
        end
    end

endmodule

### design/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master: config, sequencer and result register.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item per cycle unless the input stalls; each item is one bus tick and yields
// one result item in the cycle after it is taken, held in the result register.
// The sequencer state advances only on the cycle an item is taken.
// Input stalls only while the result register is full and the output stalls.
// Synchronous active-low reset returns to idle with config at reset values.
module i2c_eeprom_byte_master #(
    parameter int TIMER_WIDTH = i2cee_pkg::TIMER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  i2cee_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output i2cee_pkg::t_out_item              o_out_item,
    input  logic                              i_cfg_we,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import i2cee_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    logic      accept;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    i2cee_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    i2cee_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("taken item produced no result");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> o_out_item.busy_res)
        else $error("done pulse outside a transaction");

    a_idle_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.busy_res |-> o_out_item.scl && o_out_item.sda_out)
        else $error("bus driven while idle");

endmodule

### dv/i2c_eeprom_byte_master_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C EEPROM byte master: directed table, then random bus traffic.
module i2c_eeprom_byte_master_tb;
    import i2cee_pkg::*;

    typedef enum logic [4:0] {
        BP_IDLE,
        BP_STA_A, BP_STA_B, BP_STA_C, BP_STA_D,
        BP_BIT_A, BP_BIT_B, BP_BIT_C,
        BP_ACK_A, BP_ACK_W, BP_ACK_E,
        BP_RD_A, BP_RD_B, BP_RD_C, BP_RD_D,
        BP_STP_A, BP_STP_B, BP_STP_C
    } t_bus_phase;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_EVERY3} t_stall_style;

    typedef struct packed {
        t_in_item  stim;
        logic      run_out;
        logic      fixed;
        t_out_item want;
    } t_dir_row;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    localparam t_out_item OUT_IDLE    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00};
    localparam t_out_item OUT_FAIL    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00};
    localparam t_out_item OUT_FAIL_FF = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'hff};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // bus sequencer prediction
    t_bus_phase  st_phase = BP_IDLE;
    logic [15:0] st_timer = '0;
    logic [3:0]  st_bits = '0;
    logic [2:0]  st_byte_idx = '0;
    logic [7:0]  st_shift = '0;
    logic [7:0]  st_ack_cnt = '0;
    logic        st_read = 1'b0;
    logic [7:0]  st_addr = '0;
    logic [7:0]  st_data = '0;
    logic        st_fail = 1'b0;
    logic [7:0]  st_rdbyte = '0;
    logic [6:0]  cfg_dev = DEV_ADDR_RST;
    logic [7:0]  cfg_ack = ACK_TIMEOUT_RST;
    logic [15:0] cfg_ticks = PHASE_TICKS_RST;

    t_out_item    pending_ticks[$];
    t_out_item    pinned_want = '0;
    logic         pinned = 1'b0;
    logic         in_taken = 1'b0;
    int           err_cnt = 0;
    int           quiet_cycles = 0;
    int           burst_left = 20;
    bit           nack_txn = 1'b0;
    t_stall_style stall_style = STALL_NONE;
    int           stall_span = 0;
    int           stall_cnt = 0;

    t_dir_row dir_tab [14] = '{
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b0}, 1'b0, 1'b1, OUT_IDLE},
        '{'{FUNC_UNUSED, 8'hff, 8'hff, 1'b1}, 1'b0, 1'b1, OUT_IDLE},
        '{'{FUNC_WRITE,  8'hff, 8'h00, 1'b1}, 1'b1, 1'b1, OUT_IDLE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b0}, 1'b0, 1'b1, OUT_FAIL},
        '{'{FUNC_READ,   8'h00, 8'hff, 1'b1}, 1'b1, 1'b1, OUT_FAIL},
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b0}, 1'b0, 1'b1, OUT_FAIL_FF},
        '{'{FUNC_READ,   8'ha5, 8'h5a, 1'b0}, 1'b1, 1'b1, OUT_FAIL_FF},
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b1}, 1'b0, 1'b1, OUT_IDLE},
        '{'{FUNC_WRITE,  8'h5a, 8'ha5, 1'b0}, 1'b0, 1'b1, OUT_IDLE},
        '{'{FUNC_WRITE,  8'hff, 8'hff, 1'b1}, 1'b0, 1'b0, OUT_IDLE},
        '{'{FUNC_READ,   8'h00, 8'h00, 1'b0}, 1'b0, 1'b0, OUT_IDLE},
        '{'{FUNC_UNUSED, 8'h12, 8'h34, 1'b1}, 1'b0, 1'b0, OUT_IDLE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b0}, 1'b1, 1'b0, OUT_IDLE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 1'b1}, 1'b0, 1'b1, OUT_IDLE}
    };

    i2c_eeprom_byte_master i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit phase_elapsed();
        int unsigned lim;
        lim = (cfg_ticks == 0) ? 1 : cfg_ticks;
        if (st_timer + 1 >= lim) begin
            st_timer = '0;
            return 1'b1;
        end
        st_timer = st_timer + 1'b1;
        return 1'b0;
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        st_shift = b;
        st_bits = '0;
        st_phase = BP_BIT_A;
    endfunction

    // one bus tick: outputs reflect the state before the update
    function automatic t_out_item bus_tick(input t_in_item it);
        t_out_item r;
        logic      b;
        b = st_shift[7];
        r.scl = 1'b1;
        r.sda_out = 1'b1;
        case (st_phase)
            BP_STA_A: r.scl = (st_byte_idx == 0);
            BP_STA_C: r.sda_out = 1'b0;
            BP_STA_D, BP_STP_A: begin
                r.scl = 1'b0;
                r.sda_out = 1'b0;
            end
            BP_BIT_A, BP_BIT_C: begin
                r.scl = 1'b0;
                r.sda_out = b;
            end
            BP_BIT_B: r.sda_out = b;
            BP_ACK_A, BP_ACK_E, BP_RD_A, BP_RD_D: r.scl = 1'b0;
            BP_STP_B: r.sda_out = 1'b0;
            default: ;
        endcase
        r.busy_res = (st_phase != BP_IDLE);
        r.done_res = 1'b0;
        r.ack_fail = st_fail;
        r.rd_data = st_rdbyte;

        case (st_phase)
            BP_IDLE: begin
                if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
                    st_read = (it.func == FUNC_READ);
                    st_addr = it.mem_addr;
                    st_data = it.wr_data;
                    st_fail = 1'b0;
                    st_byte_idx = '0;
                    st_bits = '0;
                    st_ack_cnt = '0;
                    st_timer = '0;
                    st_phase = BP_STA_A;
                end
            end
            BP_STA_A: if (phase_elapsed()) st_phase = BP_STA_B;
            BP_STA_B: if (phase_elapsed()) st_phase = BP_STA_C;
            BP_STA_C: if (phase_elapsed()) st_phase = BP_STA_D;
            BP_STA_D: if (phase_elapsed()) load_byte({cfg_dev, st_byte_idx == 3'd2});
            BP_BIT_A: if (phase_elapsed()) st_phase = BP_BIT_B;
            BP_BIT_B: if (phase_elapsed()) st_phase = BP_BIT_C;
            BP_BIT_C: begin
                if (phase_elapsed()) begin
                    st_shift = st_shift << 1;
                    st_bits = st_bits + 1'b1;
                    st_phase = (st_bits >= 8) ? BP_ACK_A : BP_BIT_A;
                end
            end
            BP_ACK_A: begin
                if (phase_elapsed()) begin
                    st_ack_cnt = '0;
                    st_phase = BP_ACK_W;
                end
            end
            BP_ACK_W: begin
                if (!it.sda_in) begin
                    st_ack_cnt = '0;
                    st_phase = BP_ACK_E;
                end else if (st_ack_cnt >= cfg_ack) begin
                    st_fail = 1'b1;
                    st_ack_cnt = '0;
                    st_phase = BP_ACK_E;
                end else begin
                    st_ack_cnt = st_ack_cnt + 1'b1;
                end
                st_timer = '0;
            end
            BP_ACK_E: begin
                if (phase_elapsed()) begin
                    st_byte_idx = st_byte_idx + 1'b1;
                    if (st_byte_idx == 1) load_byte(st_addr);
                    else if (st_byte_idx == 2) begin
                        if (st_read) st_phase = BP_STA_A;
                        else load_byte(st_data);
                    end else if (st_byte_idx == 3 && st_read) st_phase = BP_RD_A;
                    else st_phase = BP_STP_A;
                end
            end
            BP_RD_A: begin
                if (phase_elapsed()) begin
                    st_shift = '0;
                    st_bits = '0;
                    st_phase = BP_RD_B;
                end
            end
            BP_RD_B: begin
                if (phase_elapsed()) begin
                    st_shift = {st_shift[6:0], it.sda_in};
                    st_phase = BP_RD_C;
                end
            end
            BP_RD_C: if (phase_elapsed()) st_phase = BP_RD_D;
            BP_RD_D: begin
                if (phase_elapsed()) begin
                    st_bits = st_bits + 1'b1;
                    if (st_bits >= 8) begin
                        st_rdbyte = st_shift;
                        st_phase = BP_STP_A;
                    end else begin
                        st_phase = BP_RD_B;
                    end
                end
            end
            BP_STP_A: if (phase_elapsed()) st_phase = BP_STP_B;
            BP_STP_B: if (phase_elapsed()) st_phase = BP_STP_C;
            BP_STP_C: begin
                if (phase_elapsed()) begin
                    r.done_res = 1'b1;
                    st_phase = BP_IDLE;
                end
            end
            default: begin
                st_phase = BP_IDLE;
                st_timer = '0;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_ticks.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t ns: result expected none, got %0h", $time, o_out_item);
                end else begin
                    want = pending_ticks.pop_front();
                    check_field("scl", want.scl, o_out_item.scl);
                    check_field("sda_out", want.sda_out, o_out_item.sda_out);
                    check_field("busy_res", want.busy_res, o_out_item.busy_res);
                    check_field("done_res", want.done_res, o_out_item.done_res);
                    check_field("ack_fail", want.ack_fail, o_out_item.ack_fail);
                    check_field("rd_data", want.rd_data, o_out_item.rd_data);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = bus_tick(i_in_item);
                pending_ticks.push_back(pinned ? pinned_want : want);
            end
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 150);
        end else begin
            stall_span--;
        end
        stall_cnt++;
        case (stall_style)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_HALF: i_out_stall <= 1'($urandom_range(0, 1));
            STALL_RARE: i_out_stall <= ($urandom_range(0, 7) == 0);
            default:    i_out_stall <= (stall_cnt % 3 == 0);
        endcase
    end

    task automatic feed(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(negedge i_clk); while (!in_taken);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
        end
    endtask

    task automatic set_config(input logic [6:0] dev, input logic [7:0] ack,
                              input logic [15:0] ticks);
        cfg_dev = dev;
        cfg_ack = ack;
        cfg_ticks = ticks;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DEV_ADDR;
        i_cfg_data <= {9'd0, dev};
        @(negedge i_clk);
        i_cfg_idx <= CFG_ACK_TIMEOUT;
        i_cfg_data <= {8'd0, ack};
        @(negedge i_clk);
        i_cfg_idx <= CFG_PHASE_TICKS;
        i_cfg_data <= ticks;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly complete transactions; acks usually given, some withheld
    task automatic next_tick(output t_in_item it);
        it.func = FUNC_TICK;
        it.mem_addr = 8'($urandom_range(0, 255));
        it.wr_data = 8'($urandom_range(0, 255));
        it.sda_in = 1'($urandom_range(0, 1));
        if (st_phase == BP_IDLE) begin
            if ($urandom_range(0, 7) != 0) begin
                it.func = $urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE;
                nack_txn = ($urandom_range(0, 7) == 0);
            end else begin
                it.func = $urandom_range(0, 1) ? FUNC_TICK : FUNC_UNUSED;
            end
        end else begin
            if ($urandom_range(0, 15) == 0) it.func = 2'($urandom_range(0, 3));
            if (st_phase == BP_ACK_W) it.sda_in = nack_txn | ($urandom_range(0, 2) == 0);
        end
    endtask

    task automatic run_phase(input logic [6:0] dev, input logic [7:0] ack,
                             input logic [15:0] ticks, input int n_ticks, input bit to_idle);
        t_in_item it;
        int       n;
        i_in_valid <= 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
        set_config(dev, ack, ticks);
        n = 0;
        while (n < n_ticks || (to_idle && st_phase != BP_IDLE)) begin
            next_tick(it);
            feed(it);
            n++;
        end
    endtask

    initial begin
        t_in_item it;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short bus phases keep the directed transactions brief
        set_config(DEV_ADDR_RST, 8'd3, 16'd1);

        foreach (dir_tab[r]) begin
            pinned = dir_tab[r].fixed;
            pinned_want = dir_tab[r].want;
            feed(dir_tab[r].stim);
            pinned = 1'b0;
            if (dir_tab[r].run_out) begin
                it = dir_tab[r].stim;
                it.func = FUNC_TICK;
                while (st_phase != BP_IDLE) feed(it);
            end
        end

        run_phase(7'd0, 8'd0, 16'd1, 250, 1'b1);
        run_phase(7'd127, 8'd255, 16'd0, 250, 1'b1);
        run_phase(7'($urandom_range(0, 127)), 8'($urandom_range(1, 8)), 16'd2, 250, 1'b1);
        run_phase(7'($urandom_range(0, 127)), 8'd1, 16'd3, 250, 1'b1);
        // slowest bus: the run ends inside the first start phase
        run_phase(7'($urandom_range(0, 127)), 8'd255, 16'hffff, 150, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
design/i2cee_pkg.sv
design/i2cee_cfg.sv
design/i2cee_seq.sv
design/i2c_eeprom_byte_master.sv
dv/i2c_eeprom_byte_master_tb.sv
